// ===== src/clc_pkg.sv =====
// Shared types, constants and register codes for the letter cipher.
package clc_pkg;

    // Field and register widths
    localparam int BYTE_W    = 8;
    localparam int LET_W     = 5;
    localparam int LEN_W     = 4;
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 3;
    localparam int CFG_DW    = 60;
    localparam int SUM_W     = 10;
    localparam int KEY_MAX_D = 12;

    // Letter range bounds
    localparam logic [BYTE_W-1:0] CH_UP_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z = 8'h7A;
    localparam logic [SUM_W-1:0]  ALPHA_N = 10'd26;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = 1;
    localparam int QC_W    = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_VIG  = 3'd0,
        MODE_BEAU = 3'd1,
        MODE_AUTO = 3'd2,
        MODE_ATB  = 3'd3,
        MODE_AUG  = 3'd4,
        MODE_AFF  = 3'd5
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_LEN   = 3'd1,
        REG_SHIFT = 3'd2,
        REG_AMUL  = 3'd3,
        REG_AADD  = 3'd4
    } t_reg;

    typedef struct packed {
        t_mode              mode;
        logic [LEN_W-1:0]   key_len;
        logic [LET_W-1:0]   amul;
        logic [LET_W-1:0]   aadd;
    } t_cfg;

    // One classified word: raw byte, letter flags, pre-reduction value
    typedef struct packed {
        logic               letter;
        logic               lower;
        logic [SUM_W-1:0]   sum;
        logic [BYTE_W-1:0]  raw;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               avail;
        logic [QC_W-1:0]    count;
    } t_qstat;

endpackage

// ===== src/classical_letter_cipher.sv =====
// Top level of the letter cipher: config registers, front, queue and back end.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready      | i_in_byte, i_start_of_message
//  output   | o_out_valid / i_out_ready    | o_out_byte
//  config   | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
//  One word per cycle sustained while the output is taken; an accepted word
//  goes into the queue, then into the output register. The front key-position
//  loop closes combinationally. A two-word queue parts front and back, so input
//  keeps flowing while a result waits. Reset (synchronous, active low) empties the
//  queue and output register and restores the register defaults; no clearing pass.
module classical_letter_cipher #(
    parameter int KEY_MAX = clc_pkg::KEY_MAX_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [clc_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_start_of_message,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [clc_pkg::BYTE_W-1:0]  o_out_byte,
    input  logic                        i_cfg_we,
    input  logic [clc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [clc_pkg::CFG_DW-1:0]  i_cfg_data
);
    import clc_pkg::*;

    localparam int KS_W = LET_W * KEY_MAX;

    t_cfg              r_cfg;
    logic [KS_W-1:0]   r_key_shifts;
    t_job              front_job, head_job;
    t_qstat            q_stat;
    logic              push, pop;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_VIG;
            r_cfg.key_len <= LEN_W'(1);
            r_cfg.amul    <= LET_W'(1);
            r_cfg.aadd    <= '0;
            r_key_shifts  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_MODE:  r_cfg.mode    <= t_mode'(i_cfg_data[MODE_W-1:0]);
                REG_LEN:   r_cfg.key_len <= i_cfg_data[LEN_W-1:0];
                REG_SHIFT: r_key_shifts  <= i_cfg_data[KS_W-1:0];
                REG_AMUL:  r_cfg.amul    <= i_cfg_data[LET_W-1:0];
                REG_AADD:  r_cfg.aadd    <= i_cfg_data[LET_W-1:0];
                default:   r_cfg         <= r_cfg;
            endcase
        end
    end

    assign o_in_ready = !q_stat.full;
    assign push       = i_in_valid && o_in_ready;

    clc_front #(.KEY_MAX(KEY_MAX)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_byte       (i_in_byte),
        .i_som        (i_start_of_message),
        .i_cfg        (r_cfg),
        .i_key_shifts (r_key_shifts),
        .o_job        (front_job)
    );

    clc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    clc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_avail (q_stat.avail),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_byte  (o_out_byte)
    );

    // An accepted word reaches the output from an idle pipe
    a_turnaround: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !q_stat.avail && !o_out_valid) |-> ##2 o_out_valid)
        else $error("accepted word did not reach the output in two cycles");

    // Non-letters pass through unchanged
    a_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !q_stat.avail && !o_out_valid && !front_job.letter)
        |-> ##2 (o_out_byte == $past(i_in_byte, 2)))
        else $error("non-letter byte was altered");

    // Upper case stays upper case
    a_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !q_stat.avail && !o_out_valid && front_job.letter
         && !front_job.lower)
        |-> ##2 ((o_out_byte >= CH_UP_A) && (o_out_byte <= CH_UP_Z)))
        else $error("upper-case letter left its case");

endmodule

// ===== src/clc_front.sv =====
// Front end: classify each byte, track key position and autokey history.
module clc_front #(
    parameter int KEY_MAX = clc_pkg::KEY_MAX_D
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [clc_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_som,
    input  clc_pkg::t_cfg               i_cfg,
    input  logic [5*KEY_MAX-1:0]        i_key_shifts,
    output clc_pkg::t_job               o_job
);
    import clc_pkg::*;

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam logic [LEN_W-1:0] KEY_MAX_L = LEN_W'(KEY_MAX);

    logic [KW-1:0]     r_key_pos, n_key_pos;
    logic              r_key_exh, n_key_exh;
    logic [LET_W-1:0]  r_hist [KEY_MAX];

    logic              is_up, is_lo, letter;
    logic [LET_W-1:0]  p, k, s;
    logic [KW-1:0]     pos_cur, pos;
    logic              exh_cur;
    logic [LEN_W-1:0]  eff_len;
    logic [SUM_W-1:0]  sum;

    // Classify the byte
    assign is_up  = (i_byte >= CH_UP_A) && (i_byte <= CH_UP_Z);
    assign is_lo  = (i_byte >= CH_LO_A) && (i_byte <= CH_LO_Z);
    assign letter = is_up || is_lo;
    assign p      = LET_W'(i_byte - (is_lo ? CH_LO_A : CH_UP_A));

    // Clamp key length into 1..KEY_MAX
    always_comb begin
        priority if (i_cfg.key_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_cfg.key_len > KEY_MAX_L) begin
            eff_len = KEY_MAX_L;
        end else begin
            eff_len = i_cfg.key_len;
        end
    end

    // Start of message clears position and history use
    assign pos_cur = i_som ? '0 : r_key_pos;
    assign exh_cur = i_som ? 1'b0 : r_key_exh;
    assign pos     = (LEN_W'(pos_cur) >= eff_len) ? '0 : pos_cur;
    assign k       = i_key_shifts[int'(pos)*LET_W +: LET_W];
    assign s       = exh_cur ? r_hist[pos] : k;

    // Form the value that the back end reduces mod 26
    always_comb begin
        unique case (i_cfg.mode)
            MODE_VIG:  sum = SUM_W'(p) + SUM_W'(k);
            MODE_BEAU: sum = ALPHA_N + SUM_W'(k) - SUM_W'(p);
            MODE_AUTO: sum = SUM_W'(p) + SUM_W'(s);
            MODE_ATB:  sum = SUM_W'(25) - SUM_W'(p);
            MODE_AUG:  sum = (SUM_W'(p) << 1) + SUM_W'(1);
            MODE_AFF:  sum = SUM_W'(i_cfg.amul) * SUM_W'(p) + SUM_W'(i_cfg.aadd);
            default:   sum = SUM_W'(p);
        endcase
    end

    assign o_job = '{letter: letter, lower: is_lo, sum: sum, raw: i_byte};

    // Advance the key position on letters
    always_comb begin
        n_key_pos = pos_cur;
        n_key_exh = exh_cur;
        if (letter) begin
            if (LEN_W'(pos) + LEN_W'(1) >= eff_len) begin
                n_key_pos = '0;
                n_key_exh = 1'b1;
            end else begin
                n_key_pos = pos + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos <= '0;
            r_key_exh <= 1'b0;
        end else if (i_push) begin
            r_key_pos <= n_key_pos;
            r_key_exh <= n_key_exh;
        end
    end

    // Record plaintext letters at their key position
    always_ff @(posedge i_clk) begin
        if (i_push && letter) begin
            r_hist[pos] <= p;
        end
    end

endmodule

// ===== src/clc_queue.sv =====
// Two-entry queue of classified words between front and back end.
module clc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clc_pkg::t_job   i_job,
    input  logic            i_pop,
    output clc_pkg::t_job   o_head,
    output clc_pkg::t_qstat o_stat
);
    import clc_pkg::*;

    t_job             r_mem [Q_DEPTH];
    logic [QP_W-1:0]  r_wp, r_rp;
    logic [QC_W-1:0]  r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == QC_W'(Q_DEPTH));
    assign o_stat.avail = (r_cnt != '0);
    assign o_stat.count = r_cnt;

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QP_W'(1);
            if (i_pop)  r_rp <= r_rp + QP_W'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QC_W'(1);
                2'b01:   r_cnt <= r_cnt - QC_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/clc_back.sv =====
// Back end: reduce mod 26, restore case, hold the result word.
module clc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  clc_pkg::t_job               i_job,
    input  logic                        i_avail,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [clc_pkg::BYTE_W-1:0]  o_byte
);
    import clc_pkg::*;

    logic                 r_valid;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic [18:0]          prod;
    logic [5:0]           q;
    logic [SUM_W-1:0]     q26, rem0;
    logic [LET_W-1:0]     c;

    // Estimate the quotient from below with 315/8192, then correct once
    assign prod = 19'(i_job.sum) * 19'd315;
    assign q    = prod[18:13];
    assign q26  = (SUM_W'(q) << 4) + (SUM_W'(q) << 3) + (SUM_W'(q) << 1);
    assign rem0 = i_job.sum - q26;
    assign c    = (rem0 >= ALPHA_N) ? LET_W'(rem0 - ALPHA_N) : LET_W'(rem0);

    assign n_byte = i_job.letter ?
                    ((i_job.lower ? CH_LO_A : CH_UP_A) + BYTE_W'(c)) : i_job.raw;

    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // Load on pop, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= n_byte;
        end
    end

endmodule
